// ===== rtl/core/trs_pkg.sv =====
// Shared types and constants for the teach-and-replay sequencer.
// No dependencies; imported by the lane, the point store and the top level.
package trs_pkg;

    localparam int CHANNELS      = 4;
    localparam int IN_CHANNELS   = 4;
    localparam int POS_W         = 12;
    localparam int ANGLE_W       = 8;
    localparam int LOCKOUT_W     = 16;
    localparam int TIME_W        = 32;
    localparam int STATUS_CNT_W  = 7;
    localparam int SAMPLE_MAX    = 4095;
    localparam int ANGLE_MAX     = 180;
    localparam int LOCKOUT_RESET = 250;

    // angle = floor(pos * ANGLE_MAX / SAMPLE_MAX) as a multiply by a rounded-up reciprocal
    localparam int RECIP_SHIFT = 33;
    localparam longint unsigned RECIP_FULL =
        ((longint'(1) << RECIP_SHIFT) + longint'(SAMPLE_MAX) - 1) / longint'(SAMPLE_MAX)
        * longint'(ANGLE_MAX);
    localparam int RECIP_W = $clog2(RECIP_FULL + 1);
    localparam int PROD_W  = POS_W + RECIP_W;

    localparam logic [RECIP_W-1:0]  RECIP_MUL      = RECIP_W'(RECIP_FULL);
    localparam logic [POS_W-1:0]    POS_SAT        = POS_W'(SAMPLE_MAX);
    localparam logic [ANGLE_W-1:0]  ANGLE_SAT      = ANGLE_W'(ANGLE_MAX);
    localparam logic [LOCKOUT_W-1:0] LOCKOUT_INIT  = LOCKOUT_W'(LOCKOUT_RESET);

    typedef enum logic [1:0] {
        OP_STEP = 2'd0,
        OP_SAVE = 2'd1,
        OP_GO   = 2'd2
    } op_t;

    typedef struct packed {
        logic update;
        logic load_sample;
        logic load_replay;
    } lane_ctrl_t;

endpackage

// ===== rtl/core/teach_and_replay_sequencer.sv =====
// Teach-and-replay sequencer top level: control, lanes, point store and result merge.
// A result is registered and becomes valid in the cycle after its input transaction is accepted.
// Throughput: one transaction per cycle; in_ready drops while an untaken result is held.
// Replay holds a store read at the current replay index and moves to the next as it advances.
// Reset (rst_n, async, active low) clears mode, positions, counters, pending and valid flags, lockout to 250.
// Depends on trs_pkg, trs_lane and trs_store.
module teach_and_replay_sequencer
    import trs_pkg::*;
#(
    parameter int MAX_POINTS = 64
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [LOCKOUT_W-1:0] cfg_wdata,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [1:0]           operation,
    input  logic [POS_W-1:0]     pot_sample_0,
    input  logic [POS_W-1:0]     pot_sample_1,
    input  logic [POS_W-1:0]     pot_sample_2,
    input  logic [POS_W-1:0]     pot_sample_3,
    input  logic [TIME_W-1:0]    time_ms,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [ANGLE_W-1:0]   angle_0,
    output logic [ANGLE_W-1:0]   angle_1,
    output logic [ANGLE_W-1:0]   angle_2,
    output logic [ANGLE_W-1:0]   angle_3,
    output logic                 moved,
    output logic                 mode_now,
    output logic [STATUS_CNT_W-1:0] stored_points,
    output logic                 save_dropped
);

    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam logic [CW-1:0] COUNT_MAX = CW'(MAX_POINTS);

    logic                 accept;
    logic                 out_valid_reg;
    logic [LOCKOUT_W-1:0] lockout_reg;
    logic [TIME_W-1:0]    last_press_reg;
    logic [TIME_W-1:0]    last_press_next;
    logic                 mode_reg;
    logic                 mode_next;
    logic [CW-1:0]        count_reg;
    logic [CW-1:0]        count_next;
    logic [CW-1:0]        idx_reg;
    logic [CW-1:0]        idx_next;
    logic [CW-1:0]        rd_idx;
    logic                 save_pend_reg;
    logic                 save_pend_next;
    logic                 go_pend_reg;
    logic                 go_pend_next;
    logic                 moved_reg;
    logic                 moved_next;
    logic                 dropped_reg;
    logic                 dropped_next;
    logic                 out_mode_reg;
    logic [STATUS_CNT_W-1:0] out_count_reg;
    logic [CW+STATUS_CNT_W-1:0] count_ext;

    logic [TIME_W-1:0]    elapsed;
    logic                 press_ok;
    logic                 wr_en;
    logic                 replay_hit;
    logic                 load_sample;
    lane_ctrl_t           lane_ctrl;
    op_t                  op;

    logic [POS_W-1:0]          lane_sample [CHANNELS];
    logic [POS_W-1:0]          lane_replay [CHANNELS];
    logic                      lane_changed [CHANNELS];
    logic [ANGLE_W-1:0]        lane_angle [CHANNELS];
    logic [ANGLE_W-1:0]        angle_out [IN_CHANNELS];
    logic [CHANNELS*POS_W-1:0] wr_data;
    logic [CHANNELS*POS_W-1:0] rd_data;
    logic                      any_changed;

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;
    assign op       = op_t'(operation);

    assign elapsed  = time_ms - last_press_reg;
    assign press_ok = elapsed > TIME_W'(lockout_reg);

    always_comb
    begin
        for (int c = 0; c < CHANNELS; c++)
        begin
            unique case (c)
                0:       lane_sample[c] = pot_sample_0;
                1:       lane_sample[c] = pot_sample_1;
                2:       lane_sample[c] = pot_sample_2;
                3:       lane_sample[c] = pot_sample_3;
                default: lane_sample[c] = '0;
            endcase
            wr_data[c*POS_W +: POS_W] = lane_sample[c];
            lane_replay[c] = rd_data[c*POS_W +: POS_W];
        end
    end

    assign load_sample = (op == OP_STEP) && !mode_reg;
    assign replay_hit  = (op == OP_STEP) && mode_reg && (idx_reg < count_reg);

    assign lane_ctrl.update      = accept;
    assign lane_ctrl.load_sample = load_sample;
    assign lane_ctrl.load_replay = replay_hit;

    always_comb
    begin
        any_changed = 1'b0;
        for (int c = 0; c < CHANNELS; c++)
        begin
            any_changed = any_changed | lane_changed[c];
        end
    end

    always_comb
    begin
        last_press_next = last_press_reg;
        mode_next       = mode_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        save_pend_next  = save_pend_reg;
        go_pend_next    = go_pend_reg;
        moved_next      = 1'b0;
        dropped_next    = 1'b0;
        wr_en           = 1'b0;
        unique case (op)
            OP_STEP:
            begin
                if (mode_reg)
                begin
                    if (replay_hit)
                    begin
                        idx_next   = idx_reg + CW'(1);
                        moved_next = 1'b1;
                    end
                    else
                    begin
                        idx_next = '0;
                    end
                    if (go_pend_reg)
                    begin
                        mode_next    = 1'b0;
                        go_pend_next = 1'b0;
                    end
                end
                else
                begin
                    moved_next = any_changed;
                    priority if (save_pend_reg)
                    begin
                        save_pend_next = 1'b0;
                        if (count_reg < COUNT_MAX)
                        begin
                            wr_en      = 1'b1;
                            count_next = count_reg + CW'(1);
                        end
                        else
                        begin
                            dropped_next = 1'b1;
                        end
                    end
                    else if (go_pend_reg)
                    begin
                        go_pend_next = 1'b0;
                        idx_next     = '0;
                        mode_next    = 1'b1;
                    end
                end
            end
            OP_SAVE:
            begin
                if (press_ok)
                begin
                    last_press_next = time_ms;
                    save_pend_next  = 1'b1;
                end
            end
            OP_GO:
            begin
                if (press_ok)
                begin
                    last_press_next = time_ms;
                    go_pend_next    = 1'b1;
                end
            end
            default:
            begin
                moved_next = 1'b0;
            end
        endcase
    end

    assign count_ext = {{STATUS_CNT_W{1'b0}}, count_next};
    assign rd_idx    = accept ? idx_next : idx_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lockout_reg    <= LOCKOUT_INIT;
            last_press_reg <= '0;
            mode_reg       <= 1'b0;
            count_reg      <= '0;
            idx_reg        <= '0;
            save_pend_reg  <= 1'b0;
            go_pend_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                lockout_reg <= cfg_wdata;
            end
            if (accept)
            begin
                last_press_reg <= last_press_next;
                mode_reg       <= mode_next;
                count_reg      <= count_next;
                idx_reg        <= idx_next;
                save_pend_reg  <= save_pend_next;
                go_pend_reg    <= go_pend_next;
                out_valid_reg  <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            moved_reg     <= moved_next;
            dropped_reg   <= dropped_next;
            out_mode_reg  <= mode_next;
            out_count_reg <= count_ext[STATUS_CNT_W-1:0];
        end
    end

    for (genvar c = 0; c < CHANNELS; c++)
    begin : g_lane
        trs_lane u_lane (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (lane_ctrl),
            .sample     (lane_sample[c]),
            .replay_pos (lane_replay[c]),
            .changed    (lane_changed[c]),
            .angle      (lane_angle[c])
        );
    end

    trs_store #(
        .MAX_POINTS (MAX_POINTS),
        .AW         (AW)
    ) u_store (
        .clk     (clk),
        .wr_en   (accept && wr_en),
        .wr_addr (count_reg[AW-1:0]),
        .wr_data (wr_data),
        .rd_addr (rd_idx[AW-1:0]),
        .rd_data (rd_data)
    );

    always_comb
    begin
        for (int c = 0; c < IN_CHANNELS; c++)
        begin
            angle_out[c] = '0;
        end
        for (int c = 0; c < CHANNELS; c++)
        begin
            if (c < IN_CHANNELS)
            begin
                angle_out[c] = lane_angle[c];
            end
        end
    end

    assign out_valid     = out_valid_reg;
    assign angle_0       = angle_out[0];
    assign angle_1       = angle_out[1];
    assign angle_2       = angle_out[2];
    assign angle_3       = angle_out[3];
    assign moved         = moved_reg;
    assign mode_now      = out_mode_reg;
    assign stored_points = out_count_reg;
    assign save_dropped  = dropped_reg;

endmodule

// ===== rtl/core/trs_lane.sv =====
// One axis lane: live position register, change detection and angle scaling.
// Depends on trs_pkg for widths, the reciprocal constant and the lane control struct.
module trs_lane
    import trs_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  lane_ctrl_t         ctrl,
    input  logic [POS_W-1:0]   sample,
    input  logic [POS_W-1:0]   replay_pos,
    output logic               changed,
    output logic [ANGLE_W-1:0] angle
);

    logic [POS_W-1:0]   pos_reg;
    logic [POS_W-1:0]   pos_next;
    logic [ANGLE_W-1:0] angle_reg;
    logic [ANGLE_W-1:0] angle_next;
    logic [PROD_W-1:0]  prod;

    always_comb
    begin
        priority if (ctrl.load_sample)
        begin
            pos_next = sample;
        end
        else if (ctrl.load_replay)
        begin
            pos_next = replay_pos;
        end
        else
        begin
            pos_next = pos_reg;
        end
    end

    assign changed = ctrl.load_sample && (sample != pos_reg);

    assign prod = PROD_W'(pos_next) * PROD_W'(RECIP_MUL);

    always_comb
    begin
        if (pos_next >= POS_SAT)
        begin
            angle_next = ANGLE_SAT;
        end
        else
        begin
            angle_next = prod[RECIP_SHIFT +: ANGLE_W];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
        end
        else if (ctrl.update)
        begin
            pos_reg <= pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.update)
        begin
            angle_reg <= angle_next;
        end
    end

    assign angle = angle_reg;

endmodule

// ===== rtl/core/trs_store.sv =====
// Point store: one write port, one registered read port.
// Depends on trs_pkg for the position width and channel count.
module trs_store
    import trs_pkg::*;
#(
    parameter int MAX_POINTS = 64,
    parameter int AW         = 6
)
(
    input  logic                      clk,
    input  logic                      wr_en,
    input  logic [AW-1:0]             wr_addr,
    input  logic [CHANNELS*POS_W-1:0] wr_data,
    input  logic [AW-1:0]             rd_addr,
    output logic [CHANNELS*POS_W-1:0] rd_data
);

    logic [CHANNELS*POS_W-1:0] mem [MAX_POINTS];
    logic [CHANNELS*POS_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== bench/tb_teach_and_replay_sequencer.sv =====
// Self-checking bench for teach_and_replay_sequencer: random and directed transactions
// are checked against an in-bench predictor of the teach, save, replay and lockout logic.
// Depends on trs_pkg and the teach_and_replay_sequencer RTL.
module tb_teach_and_replay_sequencer;
    timeunit 1ns;
    timeprecision 1ps;
    import trs_pkg::*;

    localparam int STORE_DEPTH = 64;
    localparam int LONG_HOLD = 300;
    localparam int TAIL_CYCLES = 8;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic [1:0]                        code;
        logic [IN_CHANNELS-1:0][POS_W-1:0] sample;
        logic [TIME_W-1:0]                 stamp;
    } arm_cmd_t;

    typedef struct packed {
        logic [CHANNELS-1:0][ANGLE_W-1:0] angle;
        logic                             moved;
        logic                             mode;
        logic [STATUS_CNT_W-1:0]          count;
        logic                             dropped;
    } arm_status_t;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    cfg_we = 1'b0;
    logic [LOCKOUT_W-1:0]    cfg_wdata = '0;
    logic                    in_valid = 1'b0;
    logic                    in_ready;
    logic [1:0]              operation = OP_STEP;
    logic [POS_W-1:0]        pot_sample_0 = '0;
    logic [POS_W-1:0]        pot_sample_1 = '0;
    logic [POS_W-1:0]        pot_sample_2 = '0;
    logic [POS_W-1:0]        pot_sample_3 = '0;
    logic [TIME_W-1:0]       time_ms = '0;
    logic                    out_valid;
    logic                    out_ready = 1'b0;
    logic [ANGLE_W-1:0]      angle_0;
    logic [ANGLE_W-1:0]      angle_1;
    logic [ANGLE_W-1:0]      angle_2;
    logic [ANGLE_W-1:0]      angle_3;
    logic                    moved;
    logic                    mode_now;
    logic [STATUS_CNT_W-1:0] stored_points;
    logic                    save_dropped;

    // predicted arm state
    logic [CHANNELS-1:0][POS_W-1:0] live_pos = '0;
    logic [CHANNELS-1:0][POS_W-1:0] points [STORE_DEPTH];
    logic [STATUS_CNT_W-1:0]        n_points = '0;
    logic [STATUS_CNT_W-1:0]        replay_at = '0;
    logic                           replaying = 1'b0;
    logic                           save_req = 1'b0;
    logic                           go_req = 1'b0;
    logic [TIME_W-1:0]              last_press = '0;
    logic [LOCKOUT_W-1:0]           lockout_cfg = LOCKOUT_INIT;

    arm_cmd_t    pending_items [$];
    arm_status_t status_due [$];
    arm_cmd_t    cur_cmd;
    int unsigned mismatches = 0;
    int unsigned queued_total = 0;
    logic        quiet_tail = 1'b0;
    int          hold_reqs = 0;
    int          hold_seen = 0;
    int          send_gap = 0;
    int          recv_gap = 0;
    logic        send_calm = 1'b0;
    logic        recv_calm = 1'b0;
    logic [IN_CHANNELS-1:0][POS_W-1:0] last_samples = '0;
    logic [TIME_W-1:0]                 press_ms = 32'h0000_0400;

    teach_and_replay_sequencer #(
        .MAX_POINTS(STORE_DEPTH)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .operation    (operation),
        .pot_sample_0 (pot_sample_0),
        .pot_sample_1 (pot_sample_1),
        .pot_sample_2 (pot_sample_2),
        .pot_sample_3 (pot_sample_3),
        .time_ms      (time_ms),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .angle_0      (angle_0),
        .angle_1      (angle_1),
        .angle_2      (angle_2),
        .angle_3      (angle_3),
        .moved        (moved),
        .mode_now     (mode_now),
        .stored_points(stored_points),
        .save_dropped (save_dropped)
    );

    always #5 clk = ~clk;

    function automatic logic [ANGLE_W-1:0] pos_to_deg(logic [POS_W-1:0] pos);
        if (pos >= SAMPLE_MAX)
            return ANGLE_SAT;
        return ANGLE_W'((32'(pos) * ANGLE_MAX) / SAMPLE_MAX);
    endfunction

    function automatic arm_status_t advance_arm(arm_cmd_t cmd);
        arm_status_t st;
        logic [TIME_W-1:0] since;
        st = '0;
        case (cmd.code)
            OP_STEP:
            begin
                if (replaying)
                begin
                    if (replay_at < n_points)
                    begin
                        live_pos = points[replay_at];
                        replay_at = replay_at + 1'b1;
                        st.moved = 1'b1;
                    end
                    else
                    begin
                        replay_at = '0;
                    end
                    if (go_req)
                    begin
                        replaying = 1'b0;
                        go_req = 1'b0;
                    end
                end
                else
                begin
                    for (int c = 0; c < CHANNELS; c++)
                    begin
                        if (cmd.sample[c] != live_pos[c])
                        begin
                            live_pos[c] = cmd.sample[c];
                            st.moved = 1'b1;
                        end
                    end
                    if (save_req)
                    begin
                        save_req = 1'b0;
                        if (n_points < STORE_DEPTH)
                        begin
                            points[n_points] = live_pos;
                            n_points = n_points + 1'b1;
                        end
                        else
                        begin
                            st.dropped = 1'b1;
                        end
                    end
                    else if (go_req)
                    begin
                        go_req = 1'b0;
                        replay_at = '0;
                        replaying = 1'b1;
                    end
                end
            end
            OP_SAVE, OP_GO:
            begin
                since = cmd.stamp - last_press;
                if (since > lockout_cfg)
                begin
                    last_press = cmd.stamp;
                    if (cmd.code == OP_SAVE)
                        save_req = 1'b1;
                    else
                        go_req = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
        for (int c = 0; c < CHANNELS; c++)
            st.angle[c] = pos_to_deg(live_pos[c]);
        st.mode = replaying;
        st.count = n_points;
        return st;
    endfunction

    task automatic queue_cmd(logic [1:0] code, logic [IN_CHANNELS-1:0][POS_W-1:0] smp,
                             logic [TIME_W-1:0] stamp);
        arm_cmd_t cmd;
        cmd.code = code;
        cmd.sample = smp;
        cmd.stamp = stamp;
        pending_items.insert(pending_items.size(), cmd);
        queued_total++;
    endtask

    function automatic logic [IN_CHANNELS-1:0][POS_W-1:0] fresh_samples();
        if ($urandom_range(0, 3) != 0)
        begin
            for (int c = 0; c < IN_CHANNELS; c++)
            begin
                case ($urandom_range(0, 5))
                    0: last_samples[c] = '0;
                    1: last_samples[c] = POS_SAT;
                    default: last_samples[c] = POS_W'($urandom_range(0, SAMPLE_MAX));
                endcase
            end
        end
        return last_samples;
    endfunction

    task automatic queue_press(logic [1:0] code);
        logic [TIME_W-1:0] stamp;
        case ($urandom_range(0, 9))
            0:
            begin
                stamp = $urandom;
                press_ms = stamp;
            end
            1: stamp = press_ms + $urandom_range(0, lockout_cfg);
            2: stamp = press_ms + lockout_cfg;
            default:
            begin
                stamp = press_ms + lockout_cfg + 1 + $urandom_range(0, 40);
                press_ms = stamp;
            end
        endcase
        queue_cmd(code, 48'({$urandom, $urandom}), stamp);
    endtask

    task automatic queue_routine();
        int replay_steps;
        repeat ($urandom_range(1, 4))
        begin
            repeat ($urandom_range(1, 3))
                queue_cmd(OP_STEP, fresh_samples(), $urandom);
            queue_press(OP_SAVE);
            queue_cmd(OP_STEP, last_samples, $urandom);
        end
        queue_press(OP_GO);
        queue_cmd(OP_STEP, last_samples, $urandom);
        replay_steps = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 70) : $urandom_range(1, 8);
        repeat (replay_steps)
            queue_cmd(OP_STEP, fresh_samples(), $urandom);
        queue_press(OP_GO);
        queue_cmd(OP_STEP, fresh_samples(), $urandom);
    endtask

    task automatic queue_noise();
        logic [1:0] code;
        repeat ($urandom_range(1, 5))
        begin
            code = 2'($urandom_range(0, 3));
            if (code == OP_SAVE || code == OP_GO)
                queue_press(code);
            else
                queue_cmd(code, fresh_samples(), $urandom);
        end
    endtask

    task automatic fill_phase(int unsigned count);
        int unsigned goal;
        goal = queued_total + count;
        while (queued_total < goal)
        begin
            if ($urandom_range(0, 3) == 0)
                queue_noise();
            else
                queue_routine();
        end
    endtask

    task automatic wait_drained();
        while (pending_items.size() != 0 || in_valid || status_due.size() != 0)
            @(negedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    task automatic write_lockout(logic [LOCKOUT_W-1:0] value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        lockout_cfg = value;
        @(negedge clk);
    endtask

    // driver
    always @(posedge clk)
    begin
        logic taken;
        taken = in_valid && in_ready;
        if (taken)
            status_due.insert(status_due.size(), advance_arm(cur_cmd));
        if ($urandom_range(0, 127) == 0)
            send_calm = !send_calm;
        if (in_valid && !taken)
        begin
            // hold
        end
        else if (send_gap > 0)
        begin
            send_gap--;
            in_valid <= 1'b0;
        end
        else if (pending_items.size() == 0)
        begin
            in_valid <= 1'b0;
        end
        else if (!quiet_tail && !send_calm && $urandom_range(0, 7) == 0)
        begin
            send_gap = $urandom_range(0, 16);
            in_valid <= 1'b0;
        end
        else
        begin
            cur_cmd = pending_items.pop_front();
            in_valid <= 1'b1;
            operation <= cur_cmd.code;
            pot_sample_0 <= cur_cmd.sample[0];
            pot_sample_1 <= cur_cmd.sample[1];
            pot_sample_2 <= cur_cmd.sample[2];
            pot_sample_3 <= cur_cmd.sample[3];
            time_ms <= cur_cmd.stamp;
        end
    end

    // monitor
    always @(posedge clk)
    begin
        arm_status_t got;
        arm_status_t want;
        if (out_valid && out_ready)
        begin
            got.angle = {angle_3, angle_2, angle_1, angle_0};
            got.moved = moved;
            got.mode = mode_now;
            got.count = stored_points;
            got.dropped = save_dropped;
            if (status_due.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, got %p", $time, got);
                mismatches++;
            end
            else
            begin
                want = status_due.pop_front();
                for (int c = 0; c < CHANNELS; c++)
                begin
                    if (got.angle[c] !== want.angle[c])
                    begin
                        $display("%0t: angle_%0d expected %0d got %0d",
                                 $time, c, want.angle[c], got.angle[c]);
                        mismatches++;
                    end
                end
                if (got.moved !== want.moved)
                begin
                    $display("%0t: moved expected %0b got %0b", $time, want.moved, got.moved);
                    mismatches++;
                end
                if (got.mode !== want.mode)
                begin
                    $display("%0t: mode_now expected %0b got %0b", $time, want.mode, got.mode);
                    mismatches++;
                end
                if (got.count !== want.count)
                begin
                    $display("%0t: stored_points expected %0d got %0d",
                             $time, want.count, got.count);
                    mismatches++;
                end
                if (got.dropped !== want.dropped)
                begin
                    $display("%0t: save_dropped expected %0b got %0b",
                             $time, want.dropped, got.dropped);
                    mismatches++;
                end
            end
        end
        if ($urandom_range(0, 127) == 0)
            recv_calm = !recv_calm;
        if (hold_seen != hold_reqs)
        begin
            hold_seen = hold_reqs;
            recv_gap = LONG_HOLD;
        end
        if (recv_gap > 0)
        begin
            recv_gap--;
            out_ready <= 1'b0;
        end
        else if (!quiet_tail && !recv_calm && $urandom_range(0, 7) == 0)
        begin
            recv_gap = $urandom_range(0, 16);
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= 1'b1;
        end
    end

    initial
    begin
        #5_000_000;
        $display("teach_and_replay_sequencer verification failed");
        $finish;
    end

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        queue_cmd(OP_STEP, '0, 32'd0);
        queue_cmd(OP_GO, '0, 32'd251);
        queue_cmd(OP_STEP, '0, $urandom);
        queue_cmd(OP_STEP, '0, $urandom);
        queue_cmd(OP_GO, '0, 32'd400);
        queue_cmd(OP_GO, '0, 32'd502);
        queue_cmd(OP_STEP, '0, $urandom);
        queue_cmd(OP_STEP, {4{POS_SAT}}, $urandom);
        queue_cmd(OP_SAVE, '0, 32'd753);
        queue_cmd(OP_STEP, {4{POS_SAT}}, $urandom);
        queue_cmd(OP_STEP, {12'hAAA, 12'hFFE, 12'h800, 12'h001}, $urandom);
        queue_cmd(OP_SAVE, {4{POS_SAT}}, 32'hFFFF_FFF0);
        queue_cmd(OP_GO, '0, 32'h0000_0100);
        queue_cmd(OP_STEP, {12'h007, 12'h800, 12'hFFF, 12'h555}, $urandom);
        queue_cmd(OP_STEP, {12'h007, 12'h800, 12'hFFF, 12'h555}, $urandom);
        queue_cmd(OP_STEP, '0, $urandom);
        queue_cmd(OP_SAVE, '0, 32'h0000_0200);
        queue_cmd(OP_STEP, '0, $urandom);
        queue_cmd(OP_STEP, '0, $urandom);
        queue_cmd(OP_UNUSED, {4{POS_SAT}}, $urandom);
        queue_cmd(OP_GO, '0, 32'h0000_0400);
        queue_cmd(OP_STEP, '0, $urandom);
        queue_cmd(OP_STEP, {12'h123, 12'hEDC, 12'h001, 12'hFFF}, $urandom);
        wait_drained();

        write_lockout('0);
        fill_phase(350);
        wait_drained();

        write_lockout({LOCKOUT_W{1'b1}});
        fill_phase(300);
        wait_drained();

        // stall the result side while transactions keep coming
        write_lockout(LOCKOUT_W'($urandom_range(1, 65534)));
        fill_phase(350);
        @(posedge clk);
        hold_reqs <= hold_reqs + 1;
        wait_drained();

        write_lockout(LOCKOUT_INIT);
        @(posedge clk);
        quiet_tail <= 1'b1;
        @(negedge clk);
        fill_phase(350);
        wait_drained();

        if (mismatches == 0)
            $display("teach_and_replay_sequencer verification clean");
        else
            $display("teach_and_replay_sequencer verification failed");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/trs_pkg.sv
rtl/core/trs_lane.sv
rtl/core/trs_store.sv
rtl/core/teach_and_replay_sequencer.sv
bench/tb_teach_and_replay_sequencer.sv
